// ===== src/shell_mark_escape_scanner_defines.svh =====
// assertion macros shared by the scanner checker
`ifndef SHELL_MARK_ESCAPE_SCANNER_DEFINES_SVH
`define SHELL_MARK_ESCAPE_SCANNER_DEFINES_SVH

// same-cycle implication, quiet during reset
`define SME_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, quiet during reset
`define SME_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/sme_pkg.sv =====
`default_nettype none

package sme_pkg;

   // scanner phase codes
   localparam logic [3:0] PH_NORMAL    = 4'd0;
   localparam logic [3:0] PH_ESC       = 4'd1;
   localparam logic [3:0] PH_NUM       = 4'd2;
   localparam logic [3:0] PH_B133      = 4'd3;
   localparam logic [3:0] PH_B133_ESC  = 4'd4;
   localparam logic [3:0] PH_OTHER     = 4'd5;
   localparam logic [3:0] PH_OTHER_ESC = 4'd6;
   localparam logic [3:0] PH_STR       = 4'd7;
   localparam logic [3:0] PH_STR_ESC   = 4'd8;

   // first payload action codes
   localparam logic [2:0] ACT_NONE     = 3'd0;
   localparam logic [2:0] ACT_A        = 3'd1;
   localparam logic [2:0] ACT_B        = 3'd2;
   localparam logic [2:0] ACT_C        = 3'd3;
   localparam logic [2:0] ACT_D        = 3'd4;
   localparam logic [2:0] ACT_D_NOCODE = 3'd5;
   localparam logic [2:0] ACT_UNKNOWN  = 3'd6;

   // exit code decode stages
   localparam logic [1:0] CODE_IDLE   = 2'd0;
   localparam logic [1:0] CODE_SEMI   = 2'd1;
   localparam logic [1:0] CODE_DIGITS = 2'd2;
   localparam logic [1:0] CODE_DONE   = 2'd3;

   // mark kinds
   localparam logic [1:0] MARK_CMD_END = 2'd3;

   // byte values
   localparam logic [7:0] CH_ESC  = 8'h1B;
   localparam logic [7:0] CH_BEL  = 8'h07;
   localparam logic [7:0] CH_NUL  = 8'h00;
   localparam logic [7:0] CH_BSL  = 8'h5C;
   localparam logic [7:0] CH_OSC  = 8'h5D;
   localparam logic [7:0] CH_DCS  = 8'h50;
   localparam logic [7:0] CH_SOS  = 8'h58;
   localparam logic [7:0] CH_PM   = 8'h5E;
   localparam logic [7:0] CH_APC  = 8'h5F;
   localparam logic [7:0] CH_SEMI = 8'h3B;
   localparam logic [7:0] CH_ZERO = 8'h30;
   localparam logic [7:0] CH_NINE = 8'h39;
   localparam logic [7:0] CH_ONE  = 8'h31;
   localparam logic [7:0] CH_THREE = 8'h33;
   localparam logic [7:0] CH_A    = 8'h41;
   localparam logic [7:0] CH_B    = 8'h42;
   localparam logic [7:0] CH_C    = 8'h43;
   localparam logic [7:0] CH_D    = 8'h44;

   // exit code stops growing at or above this value
   localparam logic [29:0] CODE_CAP = 30'd100000000;

   localparam int RSP_DATA_W = 40;

   typedef struct packed {
      logic [29:0] exit_value;
      logic        exit_present;
      logic [1:0]  mark_kind;
   } mark_type;

   // phase entered by the byte after an escape
   function automatic logic [3:0] after_escape(input logic [7:0] b);
      logic [3:0] ph;
      begin
         if (b == CH_OSC) begin
            ph = PH_NUM;
         end else if (b == CH_DCS || b == CH_SOS || b == CH_PM || b == CH_APC) begin
            ph = PH_STR;
         end else if (b == CH_ESC) begin
            ph = PH_ESC;
         end else begin
            ph = PH_NORMAL;
         end
         return ph;
      end
   endfunction

endpackage

`default_nettype wire

// ===== src/sme_scan.sv =====
`default_nettype none

module sme_scan #(
   parameter int NUMBER_MAX  = 8,
   parameter int PAYLOAD_MAX = 256
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_we,
   input  wire logic              csr_wdata,
   input  wire logic              byte_fire,
   input  wire logic [7:0]        byte_data,
   output logic                   mark_valid,
   output sme_pkg::mark_type      mark
);

   localparam int LEN_W = $clog2(NUMBER_MAX);
   localparam int CNT_W = $clog2(PAYLOAD_MAX);
   localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(NUMBER_MAX - 1);
   localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(PAYLOAD_MAX - 1);
   localparam logic [LEN_W-1:0] LEN_0 = LEN_W'(0);
   localparam logic [LEN_W-1:0] LEN_1 = LEN_W'(1);
   localparam logic [LEN_W-1:0] LEN_2 = LEN_W'(2);
   localparam logic [LEN_W-1:0] LEN_3 = LEN_W'(3);

   logic             enable_ff;
   logic [3:0]       phase_ff,  phase_in;
   logic [LEN_W-1:0] len_ff,    len_in;
   logic             match_ff,  match_in;
   logic             term_ff,   term_in;
   logic [CNT_W-1:0] cnt_ff,    cnt_in;
   logic             ovf_ff,    ovf_in;
   logic [2:0]       act_ff,    act_in;
   logic [1:0]       stage_ff,  stage_in;
   logic [29:0]      acc_ff,    acc_in;

   logic        step;
   logic        is_digit;
   logic [29:0] digit_val;
   logic [29:0] acc_times_ten;
   logic        num_char_ok;
   logic        fin_ok;
   logic        fin_present;
   logic [1:0]  fin_kind;
   logic        finish;
   logic        from_escape;

   assign step      = byte_fire && enable_ff;
   assign is_digit  = byte_data inside {[sme_pkg::CH_ZERO:sme_pkg::CH_NINE]};
   assign digit_val = 30'(byte_data - sme_pkg::CH_ZERO);
   assign acc_times_ten = {acc_ff[26:0], 3'b000} + {acc_ff[28:0], 1'b0};

   // expected osc number text is "133"
   assign num_char_ok = (len_ff == LEN_0 && byte_data == sme_pkg::CH_ONE)
                     || (len_ff == LEN_1 && byte_data == sme_pkg::CH_THREE)
                     || (len_ff == LEN_2 && byte_data == sme_pkg::CH_THREE);

   // mark reported at the terminator of a 133 body
   assign fin_ok = !ovf_ff && (cnt_ff != '0)
                && (act_ff >= sme_pkg::ACT_A) && (act_ff <= sme_pkg::ACT_D_NOCODE);
   assign fin_present = (act_ff == sme_pkg::ACT_D) && (stage_ff >= sme_pkg::CODE_DIGITS);
   assign fin_kind = (act_ff == sme_pkg::ACT_D_NOCODE) ? sme_pkg::MARK_CMD_END
                                                       : 2'(act_ff - sme_pkg::ACT_A);

   assign mark.mark_kind    = fin_kind;
   assign mark.exit_present = fin_present;
   assign mark.exit_value   = fin_present ? acc_ff : 30'd0;
   assign mark_valid        = step && finish && fin_ok;

   // per-byte state update
   always_comb begin
      phase_in    = phase_ff;
      len_in      = len_ff;
      match_in    = match_ff;
      term_in     = term_ff;
      cnt_in      = cnt_ff;
      ovf_in      = ovf_ff;
      act_in      = act_ff;
      stage_in    = stage_ff;
      acc_in      = acc_ff;
      finish      = 1'b0;
      from_escape = 1'b0;
      case (phase_ff)
         sme_pkg::PH_ESC: begin
            from_escape = 1'b1;
         end
         sme_pkg::PH_NUM: begin
            if (byte_data == sme_pkg::CH_SEMI) begin
               if (match_ff && (term_ff || len_ff == LEN_3)) begin
                  phase_in = sme_pkg::PH_B133;
                  cnt_in   = '0;
                  ovf_in   = 1'b0;
                  act_in   = sme_pkg::ACT_NONE;
                  stage_in = sme_pkg::CODE_IDLE;
                  acc_in   = '0;
               end else begin
                  phase_in = sme_pkg::PH_OTHER;
               end
            end else if (byte_data == sme_pkg::CH_BEL) begin
               phase_in = sme_pkg::PH_NORMAL;
            end else if (byte_data == sme_pkg::CH_ESC) begin
               phase_in = sme_pkg::PH_ESC;
            end else if (len_ff < LEN_LIMIT) begin
               if (!term_ff) begin
                  if (byte_data == sme_pkg::CH_NUL) begin
                     if (len_ff != LEN_3) begin
                        match_in = 1'b0;
                     end
                     term_in = 1'b1;
                  end else if (!num_char_ok) begin
                     match_in = 1'b0;
                  end
               end
               len_in = len_ff + LEN_W'(1);
            end else begin
               phase_in = sme_pkg::PH_OTHER;
            end
         end
         sme_pkg::PH_B133: begin
            if (byte_data == sme_pkg::CH_BEL) begin
               finish   = 1'b1;
               phase_in = sme_pkg::PH_NORMAL;
            end else if (byte_data == sme_pkg::CH_ESC) begin
               phase_in = sme_pkg::PH_B133_ESC;
            end else if (cnt_ff < CNT_LIMIT) begin
               // incremental payload decode
               if (cnt_ff == '0) begin
                  case (byte_data)
                     sme_pkg::CH_A: act_in = sme_pkg::ACT_A;
                     sme_pkg::CH_B: act_in = sme_pkg::ACT_B;
                     sme_pkg::CH_C: act_in = sme_pkg::ACT_C;
                     sme_pkg::CH_D: act_in = sme_pkg::ACT_D;
                     default:       act_in = sme_pkg::ACT_UNKNOWN;
                  endcase
               end else if (act_ff == sme_pkg::ACT_D) begin
                  case (stage_ff)
                     sme_pkg::CODE_IDLE: begin
                        if (byte_data == sme_pkg::CH_SEMI) begin
                           stage_in = sme_pkg::CODE_SEMI;
                        end else begin
                           act_in = sme_pkg::ACT_D_NOCODE;
                        end
                     end
                     sme_pkg::CODE_SEMI: begin
                        if (is_digit) begin
                           acc_in   = digit_val;
                           stage_in = sme_pkg::CODE_DIGITS;
                        end else begin
                           act_in = sme_pkg::ACT_D_NOCODE;
                        end
                     end
                     sme_pkg::CODE_DIGITS: begin
                        if (is_digit) begin
                           if (acc_ff < sme_pkg::CODE_CAP) begin
                              acc_in = acc_times_ten + digit_val;
                           end
                        end else begin
                           stage_in = sme_pkg::CODE_DONE;
                        end
                     end
                     default: begin
                        stage_in = stage_ff;
                     end
                  endcase
               end
               cnt_in = cnt_ff + CNT_W'(1);
            end else begin
               ovf_in = 1'b1;
            end
         end
         sme_pkg::PH_B133_ESC: begin
            if (byte_data == sme_pkg::CH_BSL) begin
               finish   = 1'b1;
               phase_in = sme_pkg::PH_NORMAL;
            end else begin
               from_escape = 1'b1;
            end
         end
         sme_pkg::PH_OTHER: begin
            if (byte_data == sme_pkg::CH_BEL) begin
               phase_in = sme_pkg::PH_NORMAL;
            end else if (byte_data == sme_pkg::CH_ESC) begin
               phase_in = sme_pkg::PH_OTHER_ESC;
            end
         end
         sme_pkg::PH_OTHER_ESC: begin
            from_escape = 1'b1;
         end
         sme_pkg::PH_STR: begin
            if (byte_data == sme_pkg::CH_BEL) begin
               phase_in = sme_pkg::PH_NORMAL;
            end else if (byte_data == sme_pkg::CH_ESC) begin
               phase_in = sme_pkg::PH_STR_ESC;
            end
         end
         sme_pkg::PH_STR_ESC: begin
            if (byte_data == sme_pkg::CH_BSL) begin
               phase_in = sme_pkg::PH_NORMAL;
            end else if (byte_data != sme_pkg::CH_ESC) begin
               phase_in = sme_pkg::PH_STR;
            end
         end
         default: begin
            phase_in = (byte_data == sme_pkg::CH_ESC) ? sme_pkg::PH_ESC
                                                      : sme_pkg::PH_NORMAL;
         end
      endcase

      // byte after an escape, osc start clears the number tracker
      if (from_escape) begin
         phase_in = sme_pkg::after_escape(byte_data);
         if (byte_data == sme_pkg::CH_OSC) begin
            len_in   = '0;
            match_in = 1'b1;
            term_in  = 1'b0;
         end
      end
   end

   // scanner state, cleared by reset and by any enable write
   always_ff @(posedge clock) begin
      if (reset || csr_we) begin
         enable_ff <= reset ? 1'b0 : csr_wdata;
         phase_ff  <= sme_pkg::PH_NORMAL;
         len_ff    <= '0;
         match_ff  <= 1'b1;
         term_ff   <= 1'b0;
         cnt_ff    <= '0;
         ovf_ff    <= 1'b0;
         act_ff    <= sme_pkg::ACT_NONE;
         stage_ff  <= sme_pkg::CODE_IDLE;
         acc_ff    <= '0;
      end else if (step) begin
         phase_ff  <= phase_in;
         len_ff    <= len_in;
         match_ff  <= match_in;
         term_ff   <= term_in;
         cnt_ff    <= cnt_in;
         ovf_ff    <= ovf_in;
         act_ff    <= act_in;
         stage_ff  <= stage_in;
         acc_ff    <= acc_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/sme_out_reg.sv =====
`default_nettype none

module sme_out_reg (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              load,
   input  wire sme_pkg::mark_type                 mark,
   output logic                                   free,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [sme_pkg::RSP_DATA_W-1:0]         rsp_tdata
);

   logic              valid_ff, valid_in;
   sme_pkg::mark_type mark_ff;

   // slot is free when empty or being drained this cycle
   assign free       = !valid_ff || rsp_tready;
   assign valid_in   = load ? 1'b1 : (rsp_tready ? 1'b0 : valid_ff);
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {7'd0, mark_ff.exit_value, mark_ff.exit_present, mark_ff.mark_kind};

   // result word holding register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         mark_ff <= mark;
      end
   end

endmodule

`default_nettype wire

// ===== src/shell_mark_escape_scanner.sv =====
// a byte waits in the input register, then its result word in the result slot
// throughput: one byte per cycle while the result slot can take a word
// a stalled result slot holds the byte in the input register until it drains
// reset is synchronous, active high: clears word valids, the scanner state and
// the enable register (scanner disabled)
`default_nettype none

module shell_mark_escape_scanner #(
   parameter int NUMBER_MAX  = 8,
   parameter int PAYLOAD_MAX = 256
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // data_byte[7:0]
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [7:0]                    req_tdata,
   // mark_kind[1:0], exit_present[2], exit_value[32:3], zero[39:33]
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic [sme_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  wire logic                          csr_we,
   input  wire logic                          csr_wdata
);

   logic              in_valid_ff, in_valid_in;
   logic [7:0]        in_byte_ff;
   logic              out_free;
   logic              fire;
   logic              req_take;
   logic              mark_valid;
   sme_pkg::mark_type mark;

   // input register advances whenever the result slot can take a word
   assign fire        = in_valid_ff && out_free;
   assign req_tready  = !in_valid_ff || out_free;
   assign req_take    = req_tvalid && req_tready;
   assign in_valid_in = req_take ? 1'b1 : (fire ? 1'b0 : in_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_tdata;
      end
   end

   sme_scan #(
      .NUMBER_MAX  (NUMBER_MAX),
      .PAYLOAD_MAX (PAYLOAD_MAX)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .byte_fire  (fire),
      .byte_data  (in_byte_ff),
      .mark_valid (mark_valid),
      .mark       (mark)
   );

   sme_out_reg u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (mark_valid),
      .mark       (mark),
      .free       (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire

// ===== src/sme_checker.sv =====
`default_nettype none
`include "shell_mark_escape_scanner_defines.svh"

module sme_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          rsp_tvalid,
   input wire logic                          rsp_tready,
   input wire logic [sme_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   // stalled word stays offered
   `SME_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid, "rsp dropped while stalled")

   // stalled word keeps its contents
   `SME_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_tdata), "rsp word changed while stalled")

   // exit code only rides on command end
   `SME_ASSERT_NOW(a_exit_kind, clock, reset, rsp_tvalid && rsp_tdata[2], rsp_tdata[1:0] == sme_pkg::MARK_CMD_END, "exit code on a mark other than command end")

   // no exit code means a zero value
   `SME_ASSERT_NOW(a_exit_zero, clock, reset, rsp_tvalid && !rsp_tdata[2], rsp_tdata[32:3] == 30'd0, "exit value set without exit code")

   // padding bits stay zero
   `SME_ASSERT_NOW(a_pad_zero, clock, reset, rsp_tvalid, rsp_tdata[39:33] == 7'd0, "padding bits set in rsp word")

endmodule

bind shell_mark_escape_scanner sme_checker u_sme_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
